[rtl/cms_pkg.sv]
// Shared types, codes and constants of the CoAP message serializer.
`default_nettype none

package cms_pkg;

   // Datagram limit and the widths that follow from it
   localparam int MAX_DATAGRAM = 1024;
   localparam int BC_W         = $clog2(MAX_DATAGRAM);
   localparam int SUM_W        = 18;
   localparam int MAX_BURST    = 5;
   localparam int CNT_W        = 3;
   localparam int SIZE_W       = 11;

   // Header and option encoding constants
   localparam logic [1:0] COAP_VERSION   = 2'd1;
   localparam logic [3:0] NIB_EXT8       = 4'd13;
   localparam logic [3:0] NIB_EXT16      = 4'd14;
   localparam logic [15:0] EXT8_BASE     = 16'd13;
   localparam logic [15:0] EXT16_BASE    = 16'd269;
   localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;

   typedef enum logic [2:0] {
      OP_BEGIN      = 3'd0,
      OP_TOKEN      = 3'd1,
      OP_OPT_HEADER = 3'd2,
      OP_OPT_VALUE  = 3'd3,
      OP_PAYLOAD    = 3'd4,
      OP_END        = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [1:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] message_id;
      logic [3:0]  token_length;
      logic [15:0] payload_length;
      logic [15:0] option_number;
      logic [15:0] option_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]           count;
      logic [MAX_BURST-1:0][7:0]  bytes;
      logic                       is_end;
      logic                       too_big;
      logic [SIZE_W-1:0]          size;
   } burst_type;

   // Delta or length nibble: direct, one extended byte or two
   function automatic logic [3:0] nibble_of(input logic [15:0] v);
      logic [3:0] nib;
      if (v < EXT8_BASE) begin
         nib = v[3:0];
      end else if (v < EXT16_BASE) begin
         nib = NIB_EXT8;
      end else begin
         nib = NIB_EXT16;
      end
      return nib;
   endfunction

endpackage

`default_nettype wire

[rtl/cms_encoder.sv]
// Message state and per-request byte generation of the CoAP serializer.
`default_nettype none

module cms_encoder
   import cms_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      fire,
   input  wire req_type   item,
   output burst_type      burst
);

   logic [15:0]     run_opt_ff, run_opt_in;
   logic [BC_W-1:0] bc_ff, bc_in;
   logic            started_ff, started_in;
   logic            ovf_ff, ovf_in;
   logic [15:0]     ptotal_ff, ptotal_in;

   logic [MAX_BURST-1:0][7:0] pend;
   logic [CNT_W-1:0] n;
   logic [CNT_W-1:0] k;
   logic             emit;
   logic             first_pay;
   logic             is_end;
   logic [BC_W-1:0]  base;
   logic [15:0]      delta;
   logic [3:0]       dn, ln;
   logic [15:0]      d16, l16;
   logic [SUM_W-1:0] need_opt, need_pay, need_flush;

   always_comb begin
      delta      = item.option_number - run_opt_ff;
      dn         = nibble_of(delta);
      ln         = nibble_of(item.option_length);
      d16        = delta - EXT16_BASE;
      l16        = item.option_length - EXT16_BASE;
      need_opt   = SUM_W'(bc_ff) + SUM_W'(MAX_BURST) + SUM_W'(item.option_length);
      need_pay   = SUM_W'(bc_ff) + SUM_W'(1) + SUM_W'(ptotal_ff);
      run_opt_in = run_opt_ff;
      bc_in      = bc_ff;
      started_in = started_ff;
      ovf_in     = ovf_ff;
      ptotal_in  = ptotal_ff;
      pend       = '0;
      n          = '0;
      k          = '0;
      emit       = 1'b0;
      first_pay  = 1'b0;
      is_end     = 1'b0;
      base       = bc_ff;

      unique case (item.opcode)
         OP_BEGIN: begin
            run_opt_in = '0;
            started_in = 1'b0;
            ovf_in     = 1'b0;
            ptotal_in  = item.payload_length;
            base       = '0;
            pend[0]    = {COAP_VERSION, item.msg_type, item.token_length};
            pend[1]    = item.msg_code;
            pend[2]    = item.message_id[15:8];
            pend[3]    = item.message_id[7:0];
            n          = CNT_W'(4);
            emit       = 1'b1;
         end
         OP_TOKEN, OP_OPT_VALUE: begin
            if (!ovf_ff && !(item.opcode == OP_OPT_VALUE && started_ff)) begin
               pend[0] = item.data_byte;
               n       = CNT_W'(1);
               emit    = 1'b1;
            end
         end
         OP_OPT_HEADER: begin
            if (!ovf_ff && !started_ff) begin
               if (need_opt >= SUM_W'(MAX_DATAGRAM)) begin
                  ovf_in = 1'b1;
               end else begin
                  pend[0] = {dn, ln};
                  k = CNT_W'(1);
                  if (dn == NIB_EXT8) begin
                     pend[k] = 8'(delta - EXT8_BASE);
                     k = k + CNT_W'(1);
                  end else if (dn == NIB_EXT16) begin
                     pend[k]              = d16[15:8];
                     pend[k + CNT_W'(1)]  = d16[7:0];
                     k = k + CNT_W'(2);
                  end
                  if (ln == NIB_EXT8) begin
                     pend[k] = 8'(item.option_length - EXT8_BASE);
                     k = k + CNT_W'(1);
                  end else if (ln == NIB_EXT16) begin
                     pend[k]              = l16[15:8];
                     pend[k + CNT_W'(1)]  = l16[7:0];
                     k = k + CNT_W'(2);
                  end
                  run_opt_in = item.option_number;
                  n          = k;
                  emit       = 1'b1;
               end
            end
         end
         OP_PAYLOAD: begin
            if (!ovf_ff) begin
               if (!started_ff) begin
                  if (need_pay >= SUM_W'(MAX_DATAGRAM)) begin
                     ovf_in = 1'b1;
                  end else begin
                     pend[0]   = PAYLOAD_MARKER;
                     pend[1]   = item.data_byte;
                     n         = CNT_W'(2);
                     emit      = 1'b1;
                     first_pay = 1'b1;
                  end
               end else begin
                  pend[0] = item.data_byte;
                  n       = CNT_W'(1);
                  emit    = 1'b1;
               end
            end
         end
         OP_END: begin
            is_end = 1'b1;
            n      = CNT_W'(1);
         end
         default: begin
         end
      endcase

      // Final limit check on the bytes of this request
      need_flush = SUM_W'(base) + SUM_W'(n);
      if (emit) begin
         if (need_flush >= SUM_W'(MAX_DATAGRAM)) begin
            ovf_in = 1'b1;
            n      = '0;
         end else begin
            bc_in = BC_W'(need_flush);
            if (first_pay) begin
               started_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      burst.count   = n;
      burst.bytes   = pend;
      burst.is_end  = is_end;
      burst.too_big = ovf_ff;
      burst.size    = SIZE_W'(bc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_opt_ff <= '0;
         bc_ff      <= '0;
         started_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         ptotal_ff  <= '0;
      end else if (fire) begin
         run_opt_ff <= run_opt_in;
         bc_ff      <= bc_in;
         started_ff <= started_in;
         ovf_ff     <= ovf_in;
         ptotal_ff  <= ptotal_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cms_burst.sv]
// Result register that hands out the bytes of one request, one per cycle while rsp_stall is low.
`default_nettype none

module cms_burst
   import cms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire burst_type          burst_in,
   output logic                    free,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_in_run,
   output logic                    rsp_end_report,
   output logic                    rsp_too_big,
   output logic [SIZE_W-1:0]       rsp_message_size
);

   logic             valid_ff, valid_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   burst_type        buf_ff, buf_in;
   logic             last;
   logic             take;

   assign last = (idx_ff == buf_ff.count - CNT_W'(1));
   assign take = valid_ff && !rsp_stall;
   assign free = !valid_ff || (take && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      buf_in   = buf_ff;
      if (load && burst_in.count != '0) begin
         valid_in = 1'b1;
         idx_in   = '0;
         buf_in   = burst_in;
      end else if (take) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      buf_ff <= buf_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = buf_ff.bytes[idx_ff];
   assign rsp_last_in_run  = last;
   assign rsp_end_report   = buf_ff.is_end;
   assign rsp_too_big      = buf_ff.is_end && buf_ff.too_big;
   assign rsp_message_size = buf_ff.is_end ? buf_ff.size : '0;

endmodule

`default_nettype wire

[rtl/coap_message_serializer.sv]
// Top level of the CoAP message serializer: input register, encoder, result register.
`default_nettype none

// The serializer turns a stream of requests (begin, token byte, option
// header, option value byte, payload byte, end) into the bytes of a CoAP
// message framed per RFC 7252. Begin gives the four header bytes, an option
// header gives the delta/length byte plus up to four extended bytes, the
// first payload byte is preceded by the 0xFF marker and end gives one status
// result with the message size and the sticky too-big flag. Once the running
// size would reach the datagram limit (MAX_DATAGRAM in the package) the flag
// sets and every request but end up to the next begin yields no result. Each
// request waits in the input register and is encoded in a single pass; its
// results then leave the result register at one per cycle while rsp_stall is
// low. A byte request yields at most one result, end one, the first payload
// byte two, begin four and an option header up to five. The input register
// holds the next request while the result register still drains, so with
// rsp_stall low single-byte requests flow at one per cycle. No clearing pass
// after reset.
module coap_message_serializer
   import cms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [1:0]         req_msg_type,
   input  wire logic [7:0]         req_msg_code,
   input  wire logic [15:0]        req_message_id,
   input  wire logic [3:0]         req_token_length,
   input  wire logic [15:0]        req_payload_length,
   input  wire logic [15:0]        req_option_number,
   input  wire logic [15:0]        req_option_length,
   input  wire logic [7:0]         req_data_byte,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_in_run,
   output logic                    rsp_end_report,
   output logic                    rsp_too_big,
   output logic [SIZE_W-1:0]       rsp_message_size
);

   req_type   in_ff, in_in;
   logic      in_valid_ff, in_valid_in;
   logic      burst_free;
   logic      fire;
   burst_type burst;

   // Encode the held request once the result register can take its bytes
   assign fire      = in_valid_ff && burst_free;
   assign req_stall = in_valid_ff && !burst_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && !req_stall) begin
         in_valid_in           = 1'b1;
         in_in.opcode          = req_opcode;
         in_in.msg_type        = req_msg_type;
         in_in.msg_code        = req_msg_code;
         in_in.message_id      = req_message_id;
         in_in.token_length    = req_token_length;
         in_in.payload_length  = req_payload_length;
         in_in.option_number   = req_option_number;
         in_in.option_length   = req_option_length;
         in_in.data_byte       = req_data_byte;
      end else if (fire) begin
         // drop the request once encoded
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_ff <= in_in;
   end

   // Message state and byte generation
   cms_encoder u_encoder (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_ff),
      .burst (burst)
   );

   // Result register: advance one byte per accepted result
   cms_burst u_burst (
      .clock            (clock),
      .reset            (reset),
      .load             (fire),
      .burst_in         (burst),
      .free             (burst_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_in_run  (rsp_last_in_run),
      .rsp_end_report   (rsp_end_report),
      .rsp_too_big      (rsp_too_big),
      .rsp_message_size (rsp_message_size)
   );

`ifndef SYNTH
   // The status result is a run of its own with a zero byte
   a_end_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_report |-> rsp_last_in_run && rsp_out_byte == 8'h00)
      else $error("end report not a single zero-byte result");

   // A run that is not finished keeps presenting results
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_in_run && !rsp_stall |=> rsp_valid)
      else $error("result run cut short");

   // An end request always shows up as the next result
   a_end_reported: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.opcode == OP_END |=> rsp_valid && rsp_end_report)
      else $error("end request produced no status result");
`endif

endmodule

`default_nettype wire

[test/tb_coap_message_serializer.sv]
// Self-checking testbench for the CoAP message serializer.
`timescale 1ns / 100ps

module tb_coap_message_serializer;
   import cms_pkg::*;

   // Opcodes the block leaves unused; requests carrying them must vanish
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam int RANDOM_REQUESTS = 100;
   localparam int STALL_LIMIT     = 2000;   // cycles without any handshake
   localparam int DRAIN_CYCLES    = 16;

   // One result as the block should present it
   typedef struct packed {
      logic [7:0]        out_byte;
      logic              last_in_run;
      logic              end_report;
      logic              too_big;
      logic [SIZE_W-1:0] message_size;
   } coap_out_t;

   // One stimulus row; typed rows carry their results written out by hand
   typedef struct packed {
      req_type           req;
      logic              typed;
      logic [2:0]        n_bytes;
      logic [31:0]       bytes;     // first byte in the top lane
      logic              is_end;
      logic              flag;
      logic [SIZE_W-1:0] size;
   } stim_row_t;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_opcode;
   logic [1:0]        req_msg_type;
   logic [7:0]        req_msg_code;
   logic [15:0]       req_message_id;
   logic [3:0]        req_token_length;
   logic [15:0]       req_payload_length;
   logic [15:0]       req_option_number;
   logic [15:0]       req_option_length;
   logic [7:0]        req_data_byte;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_last_in_run;
   logic              rsp_end_report;
   logic              rsp_too_big;
   logic [SIZE_W-1:0] rsp_message_size;

   coap_message_serializer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_msg_type       (req_msg_type),
      .req_msg_code       (req_msg_code),
      .req_message_id     (req_message_id),
      .req_token_length   (req_token_length),
      .req_payload_length (req_payload_length),
      .req_option_number  (req_option_number),
      .req_option_length  (req_option_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_in_run    (rsp_last_in_run),
      .rsp_end_report     (rsp_end_report),
      .rsp_too_big        (rsp_too_big),
      .rsp_message_size   (rsp_message_size)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Serializer state mirrored by the predictor
   // ---------------------------------------------------------------------
   logic [15:0] opt_running;      // last absolute option number
   int          sent_count;       // bytes of the current message on the wire
   logic        in_payload;       // payload marker already sent
   logic        frame_cut;        // sticky datagram overflow
   logic [15:0] payload_budget;   // payload length announced on begin

   logic [7:0]  encoded[$];       // bytes one request wants to send
   coap_out_t   frame_expected[$];
   stim_row_t   directed[$];
   req_type     outgoing[$];

   int          fail_count;
   bit          quiet;            // no idling on either side while set
   int          stall_left;

   function automatic logic [3:0] size_nibble(input logic [15:0] v);
      return (v < EXT8_BASE) ? v[3:0] : (v < EXT16_BASE) ? NIB_EXT8 : NIB_EXT16;
   endfunction

   // Append the extended delta or length bytes that the nibble calls for
   function automatic void push_extension(input logic [3:0] nib, input logic [15:0] v);
      logic [15:0] rest;
      rest = v - EXT16_BASE;
      if (nib == NIB_EXT8) begin
         encoded.push_back(8'(v - EXT8_BASE));
      end else if (nib == NIB_EXT16) begin
         encoded.push_back(rest[15:8]);
         encoded.push_back(rest[7:0]);
      end
   endfunction

   // Send the staged bytes unless they would reach the datagram limit;
   // report whether they went out
   function automatic bit emit_encoded();
      int n;
      n = encoded.size();
      if (frame_cut) return 1'b0;
      if (sent_count + n >= MAX_DATAGRAM) begin
         frame_cut = 1'b1;
         return 1'b0;
      end
      for (int k = 0; k < n; k++)
         frame_expected.push_back({encoded[k], k == n - 1, 1'b0, 1'b0, SIZE_W'(0)});
      sent_count += n;
      return 1'b1;
   endfunction

   // Predict the results of one accepted request and advance the state
   function automatic void serialize_request(input req_type r);
      logic [15:0] delta;
      logic [3:0]  dnib;
      logic [3:0]  lnib;
      encoded.delete();
      case (r.opcode)
         OP_BEGIN: begin
            opt_running    = '0;
            sent_count     = 0;
            in_payload     = 1'b0;
            frame_cut      = 1'b0;
            payload_budget = r.payload_length;
            encoded.push_back({COAP_VERSION, r.msg_type, r.token_length});
            encoded.push_back(r.msg_code);
            encoded.push_back(r.message_id[15:8]);
            encoded.push_back(r.message_id[7:0]);
            void'(emit_encoded());
         end
         OP_TOKEN, OP_OPT_VALUE: begin
            // option value bytes die once the payload runs; tokens pass anywhere
            if (!frame_cut && !(r.opcode == OP_OPT_VALUE && in_payload)) begin
               encoded.push_back(r.data_byte);
               void'(emit_encoded());
            end
         end
         OP_OPT_HEADER: begin
            if (!frame_cut && !in_payload) begin
               if (sent_count + 5 + int'(r.option_length) >= MAX_DATAGRAM) begin
                  frame_cut = 1'b1;
               end else begin
                  delta = r.option_number - opt_running;   // wraps on descending numbers
                  dnib  = size_nibble(delta);
                  lnib  = size_nibble(r.option_length);
                  encoded.push_back({dnib, lnib});
                  push_extension(dnib, delta);
                  push_extension(lnib, r.option_length);
                  opt_running = r.option_number;
                  void'(emit_encoded());
               end
            end
         end
         OP_PAYLOAD: begin
            if (!frame_cut) begin
               if (in_payload) begin
                  encoded.push_back(r.data_byte);
                  void'(emit_encoded());
               end else if (sent_count + 1 + int'(payload_budget) >= MAX_DATAGRAM) begin
                  frame_cut = 1'b1;
               end else begin
                  encoded.push_back(PAYLOAD_MARKER);
                  encoded.push_back(r.data_byte);
                  if (emit_encoded()) in_payload = 1'b1;
               end
            end
         end
         OP_END: begin
            frame_expected.push_back({8'h00, 1'b1, 1'b1, frame_cut, SIZE_W'(sent_count)});
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------
   function automatic req_type random_req();
      logic [95:0] noise;
      noise = {$urandom(), $urandom(), $urandom()};
      return req_type'(noise[$bits(req_type)-1:0]);
   endfunction

   function automatic req_type mk_data(input logic [2:0] op, input logic [7:0] b);
      req_type r;
      r = random_req();
      r.opcode    = op;
      r.data_byte = b;
      return r;
   endfunction

   function automatic req_type mk_opt(input logic [15:0] num, input logic [15:0] len);
      req_type r;
      r = random_req();
      r.opcode        = OP_OPT_HEADER;
      r.option_number = num;
      r.option_length = len;
      return r;
   endfunction

   function automatic req_type mk_begin(input logic [1:0] typ, input logic [7:0] code,
                                        input logic [15:0] mid, input logic [3:0] tkl,
                                        input logic [15:0] plen);
      req_type r;
      r = random_req();
      r.opcode         = OP_BEGIN;
      r.msg_type       = typ;
      r.msg_code       = code;
      r.message_id     = mid;
      r.token_length   = tkl;
      r.payload_length = plen;
      return r;
   endfunction

   function automatic stim_row_t predicted_row(input req_type r);
      stim_row_t s;
      s     = '0;
      s.req = r;
      return s;
   endfunction

   function automatic stim_row_t fixed_bytes_row(input req_type r, input logic [2:0] n,
                                                 input logic [31:0] b);
      stim_row_t s;
      s         = predicted_row(r);
      s.typed   = 1'b1;
      s.n_bytes = n;
      s.bytes   = b;
      return s;
   endfunction

   function automatic stim_row_t fixed_status_row(input logic flag,
                                                  input logic [SIZE_W-1:0] size);
      stim_row_t s;
      s        = predicted_row(mk_data(OP_END, 8'h00));
      s.typed  = 1'b1;
      s.is_end = 1'b1;
      s.flag   = flag;
      s.size   = size;
      return s;
   endfunction

   // A well-formed message with random content; sometimes the end is left off
   task automatic queue_message();
      req_type     r;
      logic [15:0] num;
      int          n_pay;
      r = mk_begin(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)), 16'd0);
      case ($urandom_range(0, 9))
         0:       r.payload_length = 16'($urandom_range(0, 65535));
         1:       r.payload_length = 16'($urandom_range(1000, 1030));
         default: r.payload_length = 16'($urandom_range(0, 6));
      endcase
      outgoing.push_back(r);
      n_pay = (r.payload_length < 16'd8) ? int'(r.payload_length) : $urandom_range(1, 3);
      repeat (int'(r.token_length))
         outgoing.push_back(mk_data(OP_TOKEN, 8'($urandom_range(0, 255))));
      num = '0;
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 9))
            0:       num = 16'($urandom_range(0, 65535));
            1, 2:    num = num + 16'($urandom_range(13, 700));
            default: num = num + 16'($urandom_range(0, 14));
         endcase
         case ($urandom_range(0, 9))
            0:       r = mk_opt(num, 16'($urandom_range(0, 65535)));
            1:       r = mk_opt(num, 16'($urandom_range(13, 1100)));
            default: r = mk_opt(num, 16'($urandom_range(0, 4)));
         endcase
         outgoing.push_back(r);
         repeat ((r.option_length < 16'd4) ? int'(r.option_length) : 4)
            outgoing.push_back(mk_data(OP_OPT_VALUE, 8'($urandom_range(0, 255))));
      end
      repeat (n_pay)
         outgoing.push_back(mk_data(OP_PAYLOAD, 8'($urandom_range(0, 255))));
      if ($urandom_range(0, 9) != 0)
         outgoing.push_back(mk_data(OP_END, 8'($urandom_range(0, 255))));
   endtask

   // ---------------------------------------------------------------------
   // Request driver: present, hold through stalls, record the prediction
   // ---------------------------------------------------------------------
   task automatic send_request(input stim_row_t row);
      int base;
      req_opcode         <= row.req.opcode;
      req_msg_type       <= row.req.msg_type;
      req_msg_code       <= row.req.msg_code;
      req_message_id     <= row.req.message_id;
      req_token_length   <= row.req.token_length;
      req_payload_length <= row.req.payload_length;
      req_option_number  <= row.req.option_number;
      req_option_length  <= row.req.option_length;
      req_data_byte      <= row.req.data_byte;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: advance the predictor, swap in typed results
      base = frame_expected.size();
      serialize_request(row.req);
      if (row.typed) begin
         while (frame_expected.size() > base) void'(frame_expected.pop_back());
         if (row.is_end) begin
            frame_expected.push_back({8'h00, 1'b1, 1'b1, row.flag, row.size});
         end else begin
            for (int k = 0; k < int'(row.n_bytes); k++)
               frame_expected.push_back({row.bytes[31 - 8*k -: 8], k == row.n_bytes - 1,
                                         1'b0, 1'b0, SIZE_W'(0)});
         end
      end
      // drop valid for a random gap now and then
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall bursts, then compare every accepted result
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      coap_out_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_expected.size() == 0) begin
            $error("result with nothing expected: byte %0h end %0b",
                   rsp_out_byte, rsp_end_report);
            fail_count++;
         end else begin
            want = frame_expected.pop_front();
            check_field("rsp_out_byte", want.out_byte, rsp_out_byte);
            check_field("rsp_last_in_run", want.last_in_run, rsp_last_in_run);
            check_field("rsp_end_report", want.end_report, rsp_end_report);
            check_field("rsp_too_big", want.too_big, rsp_too_big);
            check_field("rsp_message_size", want.message_size, rsp_message_size);
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long
   always @(posedge clock) begin
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int counted;
      req_type r;

      fail_count         = 0;
      quiet              = 1'b0;
      stall_left         = 0;
      opt_running        = '0;
      sent_count         = 0;
      in_payload         = 1'b0;
      frame_cut          = 1'b0;
      payload_budget     = '0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_opcode         <= OP_END;
      req_msg_type       <= '0;
      req_msg_code       <= '0;
      req_message_id     <= '0;
      req_token_length   <= '0;
      req_payload_length <= '0;
      req_option_number  <= '0;
      req_option_length  <= '0;
      req_data_byte      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: status right after reset, header extremes, every
      // nibble class, wrapping delta, marker, ignored and unused requests,
      // overflow on an option and on the payload announcement
      directed.push_back(fixed_status_row(1'b0, SIZE_W'(0)));
      directed.push_back(predicted_row(mk_data(OP_TOKEN, 8'hA5)));   // before any begin
      directed.push_back(fixed_bytes_row(mk_begin(2'd3, 8'hFF, 16'hFFFF, 4'hF, 16'd0),
                                         3'd4, 32'h7FFF_FFFF));
      directed.push_back(predicted_row(mk_data(OP_TOKEN, 8'h00)));
      directed.push_back(predicted_row(mk_opt(16'd0, 16'd0)));
      directed.push_back(predicted_row(mk_opt(16'd12, 16'd12)));
      directed.push_back(predicted_row(mk_opt(16'd25, 16'd13)));
      directed.push_back(predicted_row(mk_data(OP_OPT_VALUE, 8'h5A)));
      directed.push_back(predicted_row(mk_opt(16'd293, 16'd268)));
      directed.push_back(predicted_row(mk_opt(16'd562, 16'd269)));
      directed.push_back(predicted_row(mk_opt(16'd100, 16'd0)));      // descending number
      directed.push_back(predicted_row(mk_data(OP_PAYLOAD, 8'h00)));
      directed.push_back(predicted_row(mk_data(OP_PAYLOAD, 8'hFF)));
      directed.push_back(predicted_row(mk_opt(16'd700, 16'd1)));      // option after payload
      directed.push_back(predicted_row(mk_data(OP_OPT_VALUE, 8'h33)));
      directed.push_back(predicted_row(mk_data(OP_TOKEN, 8'hC3)));    // token out of place
      directed.push_back(predicted_row(mk_data(OP_SPARE_A, 8'h00)));
      directed.push_back(predicted_row(mk_data(OP_SPARE_B, 8'hFF)));
      directed.push_back(predicted_row(mk_data(OP_END, 8'h00)));
      directed.push_back(fixed_bytes_row(mk_begin(2'd0, 8'h00, 16'h0000, 4'h0, 16'd0),
                                         3'd4, 32'h4000_0000));
      directed.push_back(fixed_bytes_row(mk_opt(16'hFFFF, 16'hFFFF), 3'd0, 32'd0));
      directed.push_back(fixed_bytes_row(mk_data(OP_TOKEN, 8'h77), 3'd0, 32'd0));
      directed.push_back(fixed_status_row(1'b1, SIZE_W'(4)));
      directed.push_back(predicted_row(mk_begin(2'd1, 8'h45, 16'h1234, 4'd4, 16'd1019)));
      directed.push_back(predicted_row(mk_data(OP_PAYLOAD, 8'h11)));
      directed.push_back(fixed_status_row(1'b1, SIZE_W'(4)));
      foreach (directed[i]) send_request(directed[i]);

      // Hold the sender until the block has drained completely
      req_valid <= 1'b0;
      while (frame_expected.size() != 0) @(posedge clock);
      @(posedge clock);

      // Random part: mostly well-formed messages, sprinkled with noise
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         queue_message();
         while (outgoing.size() != 0) begin
            quiet = (counted >= 35 && counted < 50) || counted >= 75;
            if ($urandom_range(0, 11) == 0) begin
               r = random_req();
               send_request(predicted_row(r));
               if (r.opcode <= OP_END) counted++;
            end
            send_request(predicted_row(outgoing.pop_front()));
            counted++;
         end
      end

      req_valid <= 1'b0;
      while (frame_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/cms_pkg.sv
rtl/cms_encoder.sv
rtl/cms_burst.sv
rtl/coap_message_serializer.sv
test/tb_coap_message_serializer.sv
